[hw/rtl/sevc_pkg.sv]
// Shared types, codes and constants of the spin event coalescer.
// No dependencies; imported by every module of the block.
package sevc_pkg;

  // Field widths
  localparam int unsigned AMT_W  = 8;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned SEC_W  = 32;
  localparam int unsigned USEC_W = 20;
  localparam int unsigned DUR_W  = 32;

  // Default width of the running spin sum
  localparam int unsigned SUM_BITS_DEF = 16;

  // Time conversion
  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned MS_K_W      = 10;
  // Reciprocal of US_PER_MS, exact truncation for operands below 2^21
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_MUL   = ((2 ** RECIP_SHIFT) + US_PER_MS - 1) / US_PER_MS;
  localparam int unsigned RECIP_W     = $clog2(RECIP_MUL + 1);

  // Input event codes
  typedef enum logic [1:0] {
    EV_EMPTY   = 2'd0,
    EV_CLICK   = 2'd1,
    EV_SPIN    = 2'd2,
    EV_UNKNOWN = 2'd3
  } event_kind_e;

  // Result codes
  typedef enum logic [1:0] {
    RES_CLICK = 2'd0,
    RES_SPIN  = 2'd1,
    RES_ERROR = 2'd2
  } result_kind_e;

  // One result with the time pair its duration is measured over
  typedef struct packed {
    result_kind_e             kind;
    logic signed [MAG_W-1:0]  mag;
    logic [SEC_W-1:0]         start_sec;
    logic [USEC_W-1:0]        start_usec;
    logic [SEC_W-1:0]         end_sec;
    logic [USEC_W-1:0]        end_usec;
    logic                     eor;
  } span_rec_t;

endpackage

[hw/rtl/sevc_tracker.sv]
// Input register, run tracking state and result pair buffer.
// Depends on sevc_pkg; feeds sevc_duration with one span record per transfer.
module sevc_tracker #(
  parameter int unsigned SUM_BITS = sevc_pkg::SUM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         event_kind_i,
  input  logic signed [sevc_pkg::AMT_W-1:0]  amount_i,
  input  logic [sevc_pkg::SEC_W-1:0]         stamp_sec_i,
  input  logic [sevc_pkg::USEC_W-1:0]        stamp_usec_i,
  input  logic                               batch_end_i,
  output logic                               rec_valid_o,
  input  logic                               rec_ready_i,
  output sevc_pkg::span_rec_t                rec_o
);
  import sevc_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SumMax = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SumMin = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Input register
  logic                     in_vld_q;
  logic [1:0]               kind_q;
  logic signed [AMT_W-1:0]  amt_q;
  logic [SEC_W-1:0]         sec_q;
  logic [USEC_W-1:0]        usec_q;
  logic                     last_q;

  // Run state
  logic                       open_q, open_d;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic [SEC_W-1:0]           rsec_q, rsec_d;
  logic [USEC_W-1:0]          rusec_q, rusec_d;
  logic [SEC_W-1:0]           psec_q;
  logic [USEC_W-1:0]          pusec_q;

  // Result pair buffer
  logic      pair_vld_q;
  logic      two_q;
  logic      sel_q;
  span_rec_t slot0_q, slot1_q;

  logic      proc_fire, pair_free, last_slot, load;
  logic [1:0] n;
  span_rec_t r0, r1;

  logic signed [SUM_BITS:0]   sum_ext, amt_ext, sum_add;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic signed [31:0]         sum_wide, sat_wide;
  logic signed [MAG_W-1:0]    amt_mag;
  logic                       merge;

  function automatic span_rec_t mk_rec(result_kind_e k, logic signed [MAG_W-1:0] m,
                                       logic [SEC_W-1:0] ss, logic [USEC_W-1:0] su,
                                       logic [SEC_W-1:0] es, logic [USEC_W-1:0] eu,
                                       logic e);
    span_rec_t r;
    r.kind       = k;
    r.mag        = m;
    r.start_sec  = ss;
    r.start_usec = su;
    r.end_sec    = es;
    r.end_usec   = eu;
    r.eor        = e;
    return r;
  endfunction

  // Saturating add of the spin step to the running sum
  always_comb begin
    sum_ext  = (SUM_BITS+1)'(sum_q);
    amt_ext  = (SUM_BITS+1)'(amt_q);
    sum_add  = sum_ext + amt_ext;
    if (sum_add[SUM_BITS] != sum_add[SUM_BITS-1]) begin
      sum_sat = sum_add[SUM_BITS] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_add[SUM_BITS-1:0];
    end
    sum_wide = 32'(sum_q);
    sat_wide = 32'(sum_sat);
    amt_mag  = MAG_W'(amt_q);
    merge    = open_q && ((sum_q[SUM_BITS-1] && amt_q[AMT_W-1]) ||
                          (!sum_q[SUM_BITS-1] && (|sum_q) && !amt_q[AMT_W-1] && (|amt_q)));
  end

  // Event decode: up to two results and the next run state
  always_comb begin
    n       = 2'd0;
    r0      = mk_rec(RES_ERROR, '0, '0, '0, '0, '0, 1'b1);
    r1      = r0;
    open_d  = open_q;
    sum_d   = sum_q;
    rsec_d  = rsec_q;
    rusec_d = rusec_q;
    case (event_kind_e'(kind_q))
      EV_CLICK: begin
        open_d = 1'b0;
        if (open_q) begin
          r0 = mk_rec(RES_SPIN, sum_wide[MAG_W-1:0], rsec_q, rusec_q, psec_q, pusec_q, 1'b0);
          r1 = mk_rec(RES_CLICK, amt_mag, sec_q, usec_q, sec_q, usec_q, 1'b1);
          n  = 2'd2;
        end else begin
          r0 = mk_rec(RES_CLICK, amt_mag, sec_q, usec_q, sec_q, usec_q, 1'b1);
          n  = 2'd1;
        end
      end
      EV_SPIN: begin
        if (merge) begin
          sum_d = sum_sat;
          if (last_q) begin
            // batch end flushes the merged run up to this event
            r0     = mk_rec(RES_SPIN, sat_wide[MAG_W-1:0], rsec_q, rusec_q,
                            sec_q, usec_q, 1'b1);
            n      = 2'd1;
            open_d = 1'b0;
          end
        end else begin
          sum_d   = SUM_BITS'(amt_q);
          rsec_d  = sec_q;
          rusec_d = usec_q;
          open_d  = !last_q;
          if (open_q) begin
            r0 = mk_rec(RES_SPIN, sum_wide[MAG_W-1:0], rsec_q, rusec_q, psec_q, pusec_q,
                        !last_q);
            r1 = mk_rec(RES_SPIN, amt_mag, sec_q, usec_q, sec_q, usec_q, 1'b1);
            n  = last_q ? 2'd2 : 2'd1;
          end else if (last_q) begin
            r0 = mk_rec(RES_SPIN, amt_mag, sec_q, usec_q, sec_q, usec_q, 1'b1);
            n  = 2'd1;
          end
        end
      end
      EV_UNKNOWN: begin
        open_d = 1'b0;
        sum_d  = '0;
        n      = 2'd1;
      end
      default: begin
        // empty event: only a batch end flush can come of it
        if (last_q && open_q) begin
          r0     = mk_rec(RES_SPIN, sum_wide[MAG_W-1:0], rsec_q, rusec_q, sec_q, usec_q,
                          1'b1);
          n      = 2'd1;
          open_d = 1'b0;
        end
      end
    endcase
  end

  // Handshake between input register, pair buffer and downstream
  assign last_slot  = !two_q || sel_q;
  assign pair_free  = !pair_vld_q || (rec_ready_i && last_slot);
  assign proc_fire  = in_vld_q && ((n == 2'd0) || pair_free);
  assign load       = proc_fire && (n != 2'd0);
  assign in_ready_o = !in_vld_q || proc_fire;

  assign rec_valid_o = pair_vld_q;
  assign rec_o       = sel_q ? slot1_q : slot0_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= event_kind_i;
      amt_q  <= amount_i;
      sec_q  <= stamp_sec_i;
      usec_q <= stamp_usec_i;
      last_q <= batch_end_i;
    end
  end

  // Run state update, once per processed event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      sum_q   <= '0;
      rsec_q  <= '0;
      rusec_q <= '0;
      psec_q  <= '0;
      pusec_q <= '0;
    end else if (proc_fire) begin
      open_q  <= open_d;
      sum_q   <= sum_d;
      rsec_q  <= rsec_d;
      rusec_q <= rusec_d;
      psec_q  <= sec_q;
      pusec_q <= usec_q;
    end
  end

  // Pair buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_vld_q <= 1'b0;
      two_q      <= 1'b0;
      sel_q      <= 1'b0;
    end else if (load) begin
      pair_vld_q <= 1'b1;
      two_q      <= (n == 2'd2);
      sel_q      <= 1'b0;
    end else if (pair_vld_q && rec_ready_i) begin
      if (last_slot) begin
        pair_vld_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot0_q <= r0;
      slot1_q <= r1;
    end
  end

endmodule

[hw/rtl/sevc_duration.sv]
// Two-stage duration unit: seconds and microsecond products, then the sum.
// Depends on sevc_pkg; its second stage is the block's result register.
module sevc_duration (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rec_valid_i,
  output logic                               rec_ready_o,
  input  sevc_pkg::span_rec_t                rec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         result_kind_o,
  output logic signed [sevc_pkg::MAG_W-1:0]  magnitude_o,
  output logic [sevc_pkg::SEC_W-1:0]         start_sec_o,
  output logic [sevc_pkg::USEC_W-1:0]        start_usec_o,
  output logic signed [sevc_pkg::DUR_W-1:0]  duration_ms_o,
  output logic                               end_of_run_o
);
  import sevc_pkg::*;

  localparam int unsigned SecProdW = SEC_W + MS_K_W;
  localparam int unsigned UsProdW  = USEC_W + 1 + RECIP_W;
  localparam int unsigned QuotW    = UsProdW - RECIP_SHIFT;
  localparam logic [MS_K_W-1:0]  MsK    = MS_K_W'(MS_PER_SEC);
  localparam logic [RECIP_W-1:0] RecipK = RECIP_W'(RECIP_MUL);

  // Stage 1 registers
  logic                    s1_vld_q;
  logic [1:0]              s1_kind_q;
  logic signed [MAG_W-1:0] s1_mag_q;
  logic [SEC_W-1:0]        s1_ssec_q;
  logic [USEC_W-1:0]       s1_susec_q;
  logic                    s1_eor_q;
  logic [DUR_W-1:0]        s1_secms_q;
  logic                    s1_neg_q;
  logic [UsProdW-1:0]      s1_qprod_q;

  // Stage 2 (output) valid
  logic s2_vld_q;
  logic s1_ready, s2_load;

  logic [SEC_W-1:0]         dsec;
  logic [SecProdW-1:0]      sec_prod;
  logic signed [USEC_W:0]   dusec;
  logic [USEC_W:0]          dusec_abs;
  logic [UsProdW-1:0]       us_prod;
  logic [DUR_W-1:0]         quot;
  logic [DUR_W-1:0]         dur;

  assign s2_load     = s1_vld_q && (!s2_vld_q || out_ready_i);
  assign s1_ready    = !s1_vld_q || s2_load;
  assign rec_ready_o = s1_ready;
  assign out_valid_o = s2_vld_q;

  // Seconds term and truncated microsecond quotient via reciprocal
  always_comb begin
    dsec      = rec_i.end_sec - rec_i.start_sec;
    sec_prod  = dsec * MsK;
    dusec     = $signed({1'b0, rec_i.end_usec}) - $signed({1'b0, rec_i.start_usec});
    dusec_abs = dusec[USEC_W] ? (USEC_W+1)'(-dusec) : (USEC_W+1)'(dusec);
    us_prod   = dusec_abs * RecipK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid_i && s1_ready) begin
      s1_kind_q  <= rec_i.kind;
      s1_mag_q   <= rec_i.mag;
      s1_ssec_q  <= rec_i.start_sec;
      s1_susec_q <= rec_i.start_usec;
      s1_eor_q   <= rec_i.eor;
      s1_secms_q <= sec_prod[DUR_W-1:0];
      s1_neg_q   <= dusec[USEC_W];
      s1_qprod_q <= us_prod;
    end
  end

  // Combine: quotient truncates toward zero, so apply sign after dividing
  always_comb begin
    quot = DUR_W'(s1_qprod_q[UsProdW-1 -: QuotW]);
    dur  = s1_neg_q ? (s1_secms_q - quot) : (s1_secms_q + quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_load) begin
      s2_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      s2_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      result_kind_o <= s1_kind_q;
      magnitude_o   <= s1_mag_q;
      start_sec_o   <= s1_ssec_q;
      start_usec_o  <= s1_susec_q;
      duration_ms_o <= $signed(dur);
      end_of_run_o  <= s1_eor_q;
    end
  end

endmodule

[hw/rtl/spin_event_coalescer_core.sv]
// Top level of the spin event coalescer.
// Depends on sevc_pkg, sevc_tracker and sevc_duration.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one timestamped knob
//   event per transfer; output channel (out_valid_o / out_ready_i) carries
//   one result per transfer. Each event yields zero, one or two results;
//   end_of_run_o marks the last result of an event.
//   Path: an event is registered on acceptance, decoded against the run
//   state and loaded into the pair buffer, then passes the two-stage
//   duration unit, whose second stage is the output register.
//   Throughput: one event per cycle while events yield at most one result
//   and the receiver does not stall; an event yielding two results holds the
//   pair buffer, and the next event with results waits until both have left.
//   Empty events with no flush use no output slot.
//   Reset clears the run state, the previous-event time and all valid flags.
//   When the receiver stalls, results wait in the output register and the
//   pipeline stages behind it; the input keeps accepting until these and
//   the input register are full, then in_ready_o drops.
module spin_event_coalescer_core #(
  parameter int unsigned SUM_BITS = sevc_pkg::SUM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         event_kind_i,
  input  logic signed [sevc_pkg::AMT_W-1:0]  amount_i,
  input  logic [sevc_pkg::SEC_W-1:0]         stamp_sec_i,
  input  logic [sevc_pkg::USEC_W-1:0]        stamp_usec_i,
  input  logic                               batch_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         result_kind_o,
  output logic signed [sevc_pkg::MAG_W-1:0]  magnitude_o,
  output logic [sevc_pkg::SEC_W-1:0]         start_sec_o,
  output logic [sevc_pkg::USEC_W-1:0]        start_usec_o,
  output logic signed [sevc_pkg::DUR_W-1:0]  duration_ms_o,
  output logic                               end_of_run_o
);
  import sevc_pkg::*;

  logic      rec_valid, rec_ready;
  span_rec_t rec;

  sevc_tracker #(
    .SUM_BITS (SUM_BITS)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .event_kind_i (event_kind_i),
    .amount_i     (amount_i),
    .stamp_sec_i  (stamp_sec_i),
    .stamp_usec_i (stamp_usec_i),
    .batch_end_i  (batch_end_i),
    .rec_valid_o  (rec_valid),
    .rec_ready_i  (rec_ready),
    .rec_o        (rec)
  );

  sevc_duration u_duration (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (rec_valid),
    .rec_ready_o   (rec_ready),
    .rec_i         (rec),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .magnitude_o   (magnitude_o),
    .start_sec_o   (start_sec_o),
    .start_usec_o  (start_usec_o),
    .duration_ms_o (duration_ms_o),
    .end_of_run_o  (end_of_run_o)
  );

endmodule

[hw/rtl/sevc_checker.sv]
// Port-level checks of the spin event coalescer, bound to the top level.
// Depends on sevc_pkg and spin_event_coalescer_core.
module sevc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic [1:0]                         event_kind_i,
  input  logic signed [sevc_pkg::AMT_W-1:0]  amount_i,
  input  logic [sevc_pkg::SEC_W-1:0]         stamp_sec_i,
  input  logic [sevc_pkg::USEC_W-1:0]        stamp_usec_i,
  input  logic                               batch_end_i,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic [1:0]                         result_kind_o,
  input  logic signed [sevc_pkg::MAG_W-1:0]  magnitude_o,
  input  logic [sevc_pkg::SEC_W-1:0]         start_sec_o,
  input  logic [sevc_pkg::USEC_W-1:0]        start_usec_o,
  input  logic signed [sevc_pkg::DUR_W-1:0]  duration_ms_o,
  input  logic                               end_of_run_o
);
  import sevc_pkg::*;

  // A waiting event holds until its transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(event_kind_i) &&
      $stable(amount_i) && $stable(stamp_sec_i) && $stable(stamp_usec_i) &&
      $stable(batch_end_i))
    else $error("event changed while waiting");

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(magnitude_o) && $stable(start_sec_o) && $stable(start_usec_o) &&
      $stable(duration_ms_o) && $stable(end_of_run_o))
    else $error("result changed while stalled");

  // Error results carry an all-zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_ERROR) |->
      (magnitude_o == '0) && (start_sec_o == '0) && (start_usec_o == '0) &&
      (duration_ms_o == '0))
    else $error("error result with non-zero payload");

  // Nothing follows a click or an error from the same event
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((result_kind_o == RES_CLICK) || (result_kind_o == RES_ERROR)) |->
      end_of_run_o)
    else $error("click or error not last result of its event");

  // Clicks report no duration
  a_click_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RES_CLICK) |-> (duration_ms_o == '0))
    else $error("click with non-zero duration");

endmodule

bind spin_event_coalescer_core sevc_checker u_checker (.*);

[test/sevc_result_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for spin_event_coalescer_core: watches both channels, predicts the
// results of every accepted knob event and checks them in arrival order.
// Depends on sevc_pkg.
module sevc_result_checker #(
  parameter int unsigned SUM_BITS = sevc_pkg::SUM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         event_kind_i,
  input  logic signed [sevc_pkg::AMT_W-1:0]  amount_i,
  input  logic [sevc_pkg::SEC_W-1:0]         stamp_sec_i,
  input  logic [sevc_pkg::USEC_W-1:0]        stamp_usec_i,
  input  logic                               batch_end_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [1:0]                         result_kind_i,
  input  logic signed [sevc_pkg::MAG_W-1:0]  magnitude_i,
  input  logic [sevc_pkg::SEC_W-1:0]         start_sec_i,
  input  logic [sevc_pkg::USEC_W-1:0]        start_usec_i,
  input  logic signed [sevc_pkg::DUR_W-1:0]  duration_ms_i,
  input  logic                               end_of_run_i,
  output int unsigned                        mismatch_cnt_o,
  output int unsigned                        pending_cnt_o
);
  import sevc_pkg::*;

  typedef struct {
    result_kind_e               kind;
    logic signed [MAG_W-1:0]    mag;
    logic [SEC_W-1:0]           sec;
    logic [USEC_W-1:0]          usec;
    logic signed [DUR_W-1:0]    dur;
    logic                       eor;
  } knob_result_t;

  localparam longint SumHi = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SumLo = -SumHi - 1;

  // Predicted results still to be seen on the output channel
  knob_result_t pending_results[$];
  int unsigned  mismatch_cnt;

  // Shadow of the run state
  logic              run_open;
  longint            run_sum;
  logic [SEC_W-1:0]  run_start_sec;
  logic [USEC_W-1:0] run_start_usec;
  logic [SEC_W-1:0]  prior_sec;
  logic [USEC_W-1:0] prior_usec;

  initial begin
    mismatch_cnt   = 0;
    mismatch_cnt_o = 0;
    pending_cnt_o  = 0;
    run_open       = 1'b0;
    run_sum        = 0;
    run_start_sec  = '0;
    run_start_usec = '0;
    prior_sec      = '0;
    prior_usec     = '0;
  end

  // Milliseconds between two stamps, truncating toward zero, kept mod 2^32
  function automatic logic [DUR_W-1:0] elapsed_ms(input logic [SEC_W-1:0] s_sec,
                                                  input logic [USEC_W-1:0] s_usec,
                                                  input logic [SEC_W-1:0] e_sec,
                                                  input logic [USEC_W-1:0] e_usec);
    longint d_sec;
    longint d_usec;
    longint total;
    d_sec  = longint'(e_sec) - longint'(s_sec);
    d_usec = longint'(e_usec) - longint'(s_usec);
    total  = d_sec * longint'(MS_PER_SEC) + d_usec / longint'(US_PER_MS);
    return total[DUR_W-1:0];
  endfunction

  function automatic knob_result_t make_result(input result_kind_e kind,
                                               input logic signed [MAG_W-1:0] mag,
                                               input logic [SEC_W-1:0] sec,
                                               input logic [USEC_W-1:0] usec,
                                               input logic [DUR_W-1:0] dur);
    knob_result_t r;
    r.kind = kind;
    r.mag  = mag;
    r.sec  = sec;
    r.usec = usec;
    r.dur  = dur;
    r.eor  = 1'b0;
    return r;
  endfunction

  // Emit the open run, measured up to the prior stamp (the previous event's, or this event's at batch end)
  function automatic knob_result_t close_run();
    run_open = 1'b0;
    return make_result(RES_SPIN, run_sum[MAG_W-1:0], run_start_sec, run_start_usec,
                       elapsed_ms(run_start_sec, run_start_usec, prior_sec, prior_usec));
  endfunction

  // Apply one knob event to the shadow state and queue what it produces
  task automatic coalesce_event(input event_kind_e kind,
                                input logic signed [AMT_W-1:0] amt,
                                input logic [SEC_W-1:0] sec,
                                input logic [USEC_W-1:0] usec,
                                input logic last);
    knob_result_t produced[$];
    longint       merged;
    case (kind)
      EV_CLICK: begin
        if (run_open) produced.push_back(close_run());
        produced.push_back(make_result(RES_CLICK, amt, sec, usec, '0));
      end
      EV_SPIN: begin
        if (run_open && ((run_sum < 0 && amt < 0) || (run_sum > 0 && amt > 0))) begin
          merged = run_sum + longint'(amt);
          if (merged > SumHi) merged = SumHi;
          if (merged < SumLo) merged = SumLo;
          run_sum = merged;
        end else begin
          if (run_open) produced.push_back(close_run());
          run_open       = 1'b1;
          run_sum        = longint'(amt);
          run_start_sec  = sec;
          run_start_usec = usec;
        end
      end
      EV_UNKNOWN: begin
        // open run is dropped, not emitted
        run_open = 1'b0;
        run_sum  = 0;
        produced.push_back(make_result(RES_ERROR, '0, '0, '0, '0));
      end
      default: ;
    endcase
    prior_sec  = sec;
    prior_usec = usec;
    // batch end flushes against this event's own stamp
    if (last && run_open) produced.push_back(close_run());
    if (produced.size() > 0) produced[produced.size() - 1].eor = 1'b1;
    foreach (produced[i]) pending_results.push_back(produced[i]);
  endtask

  task automatic check_field(input string field, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i) begin : watch
    knob_result_t want;
    if (!rst_ni) begin
      run_open       = 1'b0;
      run_sum        = 0;
      run_start_sec  = '0;
      run_start_usec = '0;
      prior_sec      = '0;
      prior_usec     = '0;
      pending_results.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        coalesce_event(event_kind_e'(event_kind_i), amount_i, stamp_sec_i, stamp_usec_i,
                       batch_end_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d magnitude %0d",
                 result_kind_i, magnitude_i);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.kind, result_kind_i);
          check_field("magnitude", want.mag, magnitude_i);
          check_field("start_sec", want.sec, start_sec_i);
          check_field("start_usec", want.usec, start_usec_i);
          check_field("duration_ms", want.dur, duration_ms_i);
          check_field("end_of_run", want.eor, end_of_run_i);
        end
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_cnt_o  <= pending_results.size();
  end

endmodule

[test/spin_event_coalescer_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for spin_event_coalescer_core: drives knob events with random
// stalls on both channels and gives the verdict.
// Depends on sevc_pkg, the block's RTL and sevc_result_checker.
module spin_event_coalescer_core_tb;
  import sevc_pkg::*;

  localparam int unsigned SumBits   = SUM_BITS_DEF;
  localparam int unsigned NumEvents = 1900;
  localparam int unsigned IdleLimit = 4000;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               ev_kind;
  logic signed [AMT_W-1:0]  amount;
  logic [SEC_W-1:0]         stamp_sec;
  logic [USEC_W-1:0]        stamp_usec;
  logic                     batch_end;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               result_kind;
  logic signed [MAG_W-1:0]  magnitude;
  logic [SEC_W-1:0]         start_sec;
  logic [USEC_W-1:0]        start_usec;
  logic signed [DUR_W-1:0]  duration_ms;
  logic                     end_of_run;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned events_sent;
  int unsigned quiet_cycles;

  // Knob time seen by well-formed sequences
  logic [SEC_W-1:0]  now_sec;
  logic [USEC_W-1:0] now_usec;

  always #4 clk = ~clk;

  spin_event_coalescer_core #(
    .SUM_BITS (SumBits)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .event_kind_i  (ev_kind),
    .amount_i      (amount),
    .stamp_sec_i   (stamp_sec),
    .stamp_usec_i  (stamp_usec),
    .batch_end_i   (batch_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_kind_o (result_kind),
    .magnitude_o   (magnitude),
    .start_sec_o   (start_sec),
    .start_usec_o  (start_usec),
    .duration_ms_o (duration_ms),
    .end_of_run_o  (end_of_run)
  );

  sevc_result_checker #(
    .SUM_BITS (SumBits)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .event_kind_i   (ev_kind),
    .amount_i       (amount),
    .stamp_sec_i    (stamp_sec),
    .stamp_usec_i   (stamp_usec),
    .batch_end_i    (batch_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_i  (result_kind),
    .magnitude_i    (magnitude),
    .start_sec_i    (start_sec),
    .start_usec_i   (start_usec),
    .duration_ms_i  (duration_ms),
    .end_of_run_i   (end_of_run),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One event transfer; entered and left on a falling edge
  task automatic push_event(input event_kind_e kind, input logic signed [AMT_W-1:0] amt,
                            input logic [SEC_W-1:0] sec, input logic [USEC_W-1:0] usec,
                            input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    ev_kind    <= kind;
    amount     <= amt;
    stamp_sec  <= sec;
    stamp_usec <= usec;
    batch_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_sent++;
    @(negedge clk);
  endtask

  // Move knob time forward by up to max_ms, carrying into seconds
  task automatic advance_time(input int unsigned max_ms);
    int unsigned us;
    us = now_usec + $urandom_range(max_ms * 1000);
    while (us >= 1000000) begin
      us -= 1000000;
      now_sec++;
    end
    now_usec = us[USEC_W-1:0];
  endtask

  // Short batch of mostly same-signed spins with clicks, gaps and errors mixed in
  task automatic knob_burst();
    int unsigned  len;
    int unsigned  pick;
    int           sign;
    int           mag;
    event_kind_e  kind;
    logic         last;
    len  = $urandom_range(1, 10);
    sign = $urandom_range(1) ? 1 : -1;
    for (int i = 0; i < len; i++) begin
      advance_time(300);
      pick = $urandom_range(99);
      if (pick < 62)      kind = EV_SPIN;
      else if (pick < 77) kind = EV_EMPTY;
      else if (pick < 94) kind = EV_CLICK;
      else                kind = EV_UNKNOWN;
      pick = $urandom_range(99);
      if (pick < 12) sign = -sign;
      if (pick >= 95)                  mag = 0;
      else if ($urandom_range(9) == 0) mag = (sign > 0) ? 127 : 128;
      else                             mag = $urandom_range(1, 127);
      if (kind != EV_SPIN) mag = $urandom_range(255);
      last = (i == len - 1) ? ($urandom_range(3) != 0) : ($urandom_range(19) == 0);
      push_event(kind, AMT_W'((kind == EV_SPIN) ? sign * mag : mag), now_sec, now_usec,
                 last);
    end
  endtask

  // Long same-signed run that drives the sum to or near saturation
  task automatic saturating_run();
    int unsigned len;
    int          sign;
    int          mag;
    len  = (2 ** (SumBits - 1)) / 127 + $urandom_range(1, 12);
    sign = $urandom_range(1) ? 1 : -1;
    for (int i = 0; i < len; i++) begin
      advance_time(50);
      if ($urandom_range(3) == 0) mag = $urandom_range(1, 126);
      else                        mag = (sign > 0) ? 127 : 128;
      push_event(EV_SPIN, AMT_W'(sign * mag), now_sec, now_usec, i == len - 1);
    end
  endtask

  initial begin
    in_valid    = 1'b0;
    ev_kind     = EV_EMPTY;
    amount      = '0;
    stamp_sec   = '0;
    stamp_usec  = '0;
    batch_end   = 1'b0;
    out_ready   = 1'b0;
    quiet_cycles = 0;
    events_sent = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 84;
    now_sec     = $urandom;
    now_usec    = '0;
    rst_n       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, every event kind and each corner of run handling
    push_event(EV_EMPTY, 0, 0, 0, 1'b0);
    push_event(EV_CLICK, 127, 1, 500, 1'b0);
    push_event(EV_CLICK, -128, 32'hFFFF_FFFF, 20'hF_FFFF, 1'b1);
    push_event(EV_SPIN, 5, 10, 999000, 1'b0);
    push_event(EV_SPIN, 7, 11, 1000, 1'b0);
    push_event(EV_EMPTY, 0, 11, 400, 1'b0);
    // click closes the run: run then click
    push_event(EV_CLICK, 3, 12, 0, 1'b0);
    push_event(EV_SPIN, -4, 20, 0, 1'b0);
    push_event(EV_SPIN, -9, 20, 900, 1'b0);
    // opposite sign, then zero spins closing runs
    push_event(EV_SPIN, 2, 21, 0, 1'b0);
    push_event(EV_SPIN, 0, 22, 0, 1'b0);
    push_event(EV_SPIN, 3, 23, 0, 1'b0);
    push_event(EV_SPIN, 0, 24, 0, 1'b0);
    push_event(EV_SPIN, 0, 25, 0, 1'b0);
    // unknown type drops the open run
    push_event(EV_UNKNOWN, 55, 26, 0, 1'b0);
    push_event(EV_SPIN, 1, 30, 0, 1'b0);
    push_event(EV_UNKNOWN, -1, 31, 0, 1'b1);
    // spin closing a run at batch end: old run then new one
    push_event(EV_SPIN, -1, 40, 0, 1'b0);
    push_event(EV_SPIN, 6, 41, 0, 1'b1);
    // empty event at batch end flushes against its own stamp
    push_event(EV_SPIN, 127, 50, 0, 1'b0);
    push_event(EV_EMPTY, 0, 60, 123456, 1'b1);
    // wrapping and negative durations, microseconds above range
    push_event(EV_SPIN, 1, 0, 0, 1'b0);
    push_event(EV_SPIN, 1, 32'hFFFF_FFFF, 999999, 1'b1);
    push_event(EV_SPIN, -2, 100, 20'hF_FFFF, 1'b0);
    push_event(EV_CLICK, 0, 99, 0, 1'b1);

    // Random: three idling phases, each opening with a saturating run
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 12; rx_idle_pct = 84; end
        1: begin tx_idle_pct = 84; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      saturating_run();
      while (events_sent < (phase + 1) * NumEvents / 3) begin
        if ($urandom_range(99) < 75) begin
          knob_burst();
        end else begin
          // noise: any field value, stamps anywhere
          repeat ($urandom_range(1, 4))
            push_event(event_kind_e'($urandom_range(3)), AMT_W'($urandom), $urandom,
                       USEC_W'($urandom_range(20'hF_FFFF)), 1'($urandom_range(1)));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (pending_cnt != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sevc_pkg.sv
hw/rtl/sevc_tracker.sv
hw/rtl/sevc_duration.sv
hw/rtl/spin_event_coalescer_core.sv
hw/rtl/sevc_checker.sv
test/sevc_result_checker.sv
test/spin_event_coalescer_core_tb.sv
